// ===== hdl/bhu_pkg.sv =====
// Shared types and constants of the breakpoint halt unit.
package bhu_pkg;

	localparam int REQ_W  = 3;
	localparam int ADDR_W = 32;
	localparam int SLOT_W = 5;
	localparam int PERMIT_W = 8;
	localparam logic [PERMIT_W-1:0] PERMIT_MAX = 8'd255;

	typedef enum logic [REQ_W-1:0] {
		REQ_HOOK   = 3'd0,
		REQ_ADD    = 3'd1,
		REQ_REMOVE = 3'd2,
		REQ_RUN    = 3'd3,
		REQ_STEP   = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		PARK_NONE  = 2'd0,
		PARK_GATE  = 2'd1,
		PARK_BREAK = 2'd2
	} park_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_CHECK,
		ST_REMOVE,
		ST_DECIDE,
		ST_DONE
	} state_t;

	// Table update command from the sequencer.
	typedef struct packed {
		logic wr;
		logic clr;
	} tbl_op_t;

endpackage

// ===== hdl/bhu_if.sv =====
// Request and response channel interfaces of the breakpoint halt unit.
interface bhu_req_if;
	logic                        valid;
	logic                        ready;
	logic [bhu_pkg::REQ_W-1:0]   req_type;
	logic [bhu_pkg::ADDR_W-1:0]  address;
	logic                        run_flag;

	modport source (output valid, output req_type, output address, output run_flag,
		input ready);
	modport sink (input valid, input req_type, input address, input run_flag,
		output ready);
endinterface

interface bhu_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        cpu_go;
	logic                        halted;
	logic                        bp_hit;
	logic [bhu_pkg::SLOT_W-1:0]  slot;
	logic                        slot_ok;

	modport source (output valid, output cpu_go, output halted, output bp_hit,
		output slot, output slot_ok, input ready);
	modport sink (input valid, input cpu_go, input halted, input bp_hit,
		input slot, input slot_ok, output ready);
endinterface

// ===== hdl/breakpoint_halt_unit_core.sv =====
// Breakpoint halt unit: one request item in, one response item out. A fetch hook,
// unless a hook is parked or there is neither run enable nor permit, compares its
// pc against the breakpoint table one slot per cycle through the memory's
// registered read port, stopping at the first hit; a hook is accepted, scanned,
// decided and then responded to. Remove always walks the whole table; add walks
// the valid bits to the lowest free slot. Run and step requests that do not
// resume a gate-parked hook go straight to the response; one that does runs the
// full hook check on the parked pc. Items are handled one at a time; the response
// register lets the next item be accepted while a response waits to be taken.
module breakpoint_halt_unit_core #(
	parameter int NUM_BREAKPOINTS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	bhu_req_if.sink         req_ch,
	bhu_rsp_if.source       rsp_ch
);

	localparam int IDX_W = (NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BREAKPOINTS - 1);

	function automatic logic [bhu_pkg::SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W+bhu_pkg::SLOT_W-1:0] ext;
		ext = {{bhu_pkg::SLOT_W{1'b0}}, i};
		return ext[bhu_pkg::SLOT_W-1:0];
	endfunction

	bhu_pkg::state_t state_q, state_d;
	bhu_pkg::park_t  park_q;
	bhu_pkg::tbl_op_t op;

	logic [IDX_W-1:0]             op_idx;
	logic [IDX_W-1:0]             idx_q;
	logic                         issued_q;
	logic                         vld_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [bhu_pkg::ADDR_W-1:0]   pc_q;
	logic [bhu_pkg::ADDR_W-1:0]   parked_pc_q;
	logic [bhu_pkg::ADDR_W-1:0]   rd_data;
	logic [NUM_BREAKPOINTS-1:0]   valid_vec;
	logic                         run_en_q;
	logic                         step_q;
	logic                         stopped_q;
	logic [bhu_pkg::PERMIT_W-1:0] permit_q;
	logic                         res_go_q;
	logic                         res_hit_q;
	logic [bhu_pkg::SLOT_W-1:0]   res_slot_q;
	logic                         res_ok_q;
	logic                         out_valid_q;
	logic                         out_go_q;
	logic                         out_halted_q;
	logic                         out_hit_q;
	logic [bhu_pkg::SLOT_W-1:0]   out_slot_q;
	logic                         out_ok_q;
	logic                         match;
	logic                         out_load;
	logic                         accept;
	logic                         post;
	logic                         resume_gate;
	logic                         resume_break;
	bhu_pkg::req_t                req;

	bhu_bp_table #(
		.NUM_BREAKPOINTS(NUM_BREAKPOINTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx_q),
		.rd_data  (rd_data),
		.op       (op),
		.op_idx   (op_idx),
		.wr_data  (pc_q),
		.valid_vec(valid_vec)
	);

	assign req    = bhu_pkg::req_t'(req_ch.req_type);
	assign accept = req_ch.valid && req_ch.ready;
	assign match  = vld_s1 && valid_vec[idx_s1] && (rd_data == pc_q);

	// step requests, and run requests with run_flag set, post a permit or resume a parked hook
	assign post         = (req == bhu_pkg::REQ_STEP) ||
		(req == bhu_pkg::REQ_RUN && req_ch.run_flag);
	assign resume_gate  = post && (park_q == bhu_pkg::PARK_GATE);
	assign resume_break = post && (park_q == bhu_pkg::PARK_BREAK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bhu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ch.ready = 1'b0;
		op           = '0;
		op_idx       = idx_q;
		out_load     = 1'b0;
		case (state_q)
			bhu_pkg::ST_IDLE: begin
				req_ch.ready = 1'b1;
				if (req_ch.valid) begin
					case (req)
						bhu_pkg::REQ_HOOK: begin
							if (park_q != bhu_pkg::PARK_NONE) begin
								state_d = bhu_pkg::ST_DONE;
							end else if (!run_en_q && permit_q == '0) begin
								state_d = bhu_pkg::ST_DONE;
							end else begin
								state_d = bhu_pkg::ST_CHECK;
							end
						end
						bhu_pkg::REQ_ADD:    state_d = bhu_pkg::ST_ADD;
						bhu_pkg::REQ_REMOVE: state_d = bhu_pkg::ST_REMOVE;
						bhu_pkg::REQ_RUN: begin
							if (req_ch.run_flag && park_q == bhu_pkg::PARK_GATE) begin
								state_d = bhu_pkg::ST_CHECK;
							end else begin
								state_d = bhu_pkg::ST_DONE;
							end
						end
						bhu_pkg::REQ_STEP: begin
							if (park_q == bhu_pkg::PARK_GATE) begin
								state_d = bhu_pkg::ST_CHECK;
							end else begin
								state_d = bhu_pkg::ST_DONE;
							end
						end
						default: state_d = bhu_pkg::ST_DONE;
					endcase
				end
			end
			bhu_pkg::ST_ADD: begin
				if (!valid_vec[idx_q]) begin
					op.wr   = 1'b1;
					state_d = bhu_pkg::ST_DONE;
				end else if (idx_q == LAST_IDX) begin
					state_d = bhu_pkg::ST_DONE;
				end
			end
			bhu_pkg::ST_CHECK: begin
				if (match || (vld_s1 && idx_s1 == LAST_IDX)) begin
					state_d = bhu_pkg::ST_DECIDE;
				end
			end
			bhu_pkg::ST_REMOVE: begin
				if (match) begin
					op.clr = 1'b1;
					op_idx = idx_s1;
				end
				if (vld_s1 && idx_s1 == LAST_IDX) begin
					state_d = bhu_pkg::ST_DONE;
				end
			end
			bhu_pkg::ST_DECIDE: state_d = bhu_pkg::ST_DONE;
			bhu_pkg::ST_DONE: begin
				if (!out_valid_q || rsp_ch.ready) begin
					out_load = 1'b1;
					state_d  = bhu_pkg::ST_IDLE;
				end
			end
			default: state_d = bhu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			park_q      <= bhu_pkg::PARK_NONE;
			parked_pc_q <= '0;
			run_en_q    <= 1'b0;
			step_q      <= 1'b0;
			stopped_q   <= 1'b0;
			permit_q    <= '0;
			pc_q        <= '0;
			idx_q       <= '0;
			issued_q    <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			res_go_q    <= 1'b0;
			res_hit_q   <= 1'b0;
			res_slot_q  <= '0;
			res_ok_q    <= 1'b0;
		end else begin
			case (state_q)
				bhu_pkg::ST_IDLE: begin
					if (accept) begin
						res_go_q   <= resume_break;
						res_hit_q  <= 1'b0;
						res_slot_q <= '0;
						res_ok_q   <= 1'b0;
						idx_q      <= '0;
						issued_q   <= 1'b0;
						vld_s1     <= 1'b0;
						// a gate-parked hook resumes with its own pc
						pc_q       <= resume_gate ? parked_pc_q : req_ch.address;
						case (req)
							bhu_pkg::REQ_HOOK: begin
								if (park_q == bhu_pkg::PARK_NONE && !run_en_q) begin
									if (permit_q != '0) begin
										permit_q  <= permit_q - 1'b1;
										stopped_q <= 1'b0;
									end else begin
										stopped_q   <= 1'b1;
										park_q      <= bhu_pkg::PARK_GATE;
										parked_pc_q <= req_ch.address;
									end
								end
							end
							bhu_pkg::REQ_RUN, bhu_pkg::REQ_STEP: begin
								if (req == bhu_pkg::REQ_STEP) begin
									step_q   <= 1'b1;
									run_en_q <= 1'b1;
								end else begin
									run_en_q <= req_ch.run_flag;
								end
								if (post) begin
									case (park_q)
										bhu_pkg::PARK_GATE, bhu_pkg::PARK_BREAK: begin
											park_q    <= bhu_pkg::PARK_NONE;
											stopped_q <= 1'b0;
										end
										default: begin
											if (permit_q != bhu_pkg::PERMIT_MAX) begin
												permit_q <= permit_q + 1'b1;
											end
										end
									endcase
								end
							end
							default: ;
						endcase
					end
				end
				bhu_pkg::ST_ADD: begin
					if (!valid_vec[idx_q]) begin
						res_slot_q <= to_slot(idx_q);
						res_ok_q   <= 1'b1;
					end else if (idx_q != LAST_IDX) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				bhu_pkg::ST_CHECK, bhu_pkg::ST_REMOVE: begin
					// read issue one slot ahead of the compare stage
					vld_s1 <= !issued_q;
					idx_s1 <= idx_q;
					if (!issued_q) begin
						if (idx_q == LAST_IDX) begin
							issued_q <= 1'b1;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
					if (state_q == bhu_pkg::ST_CHECK && match) begin
						res_hit_q  <= 1'b1;
						res_ok_q   <= 1'b1;
						res_slot_q <= to_slot(idx_s1);
					end
				end
				bhu_pkg::ST_DECIDE: begin
					if (res_hit_q || step_q) begin
						step_q <= 1'b0;
						if (permit_q != '0) begin
							permit_q  <= permit_q - 1'b1;
							stopped_q <= 1'b0;
							res_go_q  <= 1'b1;
						end else begin
							stopped_q   <= 1'b1;
							park_q      <= bhu_pkg::PARK_BREAK;
							parked_pc_q <= pc_q;
						end
					end else begin
						res_go_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_go_q     <= 1'b0;
			out_halted_q <= 1'b0;
			out_hit_q    <= 1'b0;
			out_slot_q   <= '0;
			out_ok_q     <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= 1'b1;
			out_go_q     <= res_go_q;
			out_halted_q <= stopped_q;
			out_hit_q    <= res_hit_q;
			out_slot_q   <= res_slot_q;
			out_ok_q     <= res_ok_q;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_ch.valid   = out_valid_q;
	assign rsp_ch.cpu_go  = out_go_q;
	assign rsp_ch.halted  = out_halted_q;
	assign rsp_ch.bp_hit  = out_hit_q;
	assign rsp_ch.slot    = out_slot_q;
	assign rsp_ch.slot_ok = out_ok_q;

`ifndef ASSERT_OFF
	// a parked hook always leaves the cpu flagged as stopped
	a_park_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(park_q != bhu_pkg::PARK_NONE) |-> stopped_q)
		else $error("parked hook without stopped flag");

	// add only ever fills a free slot
	a_add_free: assert property (@(posedge clk) disable iff (!arst_n)
		op.wr |-> (!valid_vec[op_idx] && !op.clr))
		else $error("add overwrote a valid slot");

	// permit count moves by at most one per cycle
	a_permit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(permit_q != $past(permit_q)) |->
		(permit_q == $past(permit_q) + 8'd1 || permit_q == $past(permit_q) - 8'd1))
		else $error("permit count jumped");
`endif

endmodule

// ===== hdl/bhu_bp_table.sv =====
// Breakpoint address memory with registered read and per-slot valid flops.
module bhu_bp_table #(
	parameter int NUM_BREAKPOINTS = 32
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic [((NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1)-1:0] rd_idx,
	output logic [bhu_pkg::ADDR_W-1:0]                        rd_data,
	input  bhu_pkg::tbl_op_t                                  op,
	input  logic [((NUM_BREAKPOINTS > 1) ? $clog2(NUM_BREAKPOINTS) : 1)-1:0] op_idx,
	input  logic [bhu_pkg::ADDR_W-1:0]                        wr_data,
	output logic [NUM_BREAKPOINTS-1:0]                        valid_vec
);

	logic [bhu_pkg::ADDR_W-1:0] bp_mem_q [NUM_BREAKPOINTS];
	logic [bhu_pkg::ADDR_W-1:0] rd_data_q;
	logic [NUM_BREAKPOINTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (op.wr) begin
			bp_mem_q[op_idx] <= wr_data;
		end
		rd_data_q <= bp_mem_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (op.wr) begin
			valid_q[op_idx] <= 1'b1;
		end else if (op.clr) begin
			valid_q[op_idx] <= 1'b0;
		end
	end

	assign rd_data   = rd_data_q;
	assign valid_vec = valid_q;

endmodule
